>>> hdl/shs_pkg.sv
package shs_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] chain_t;
	typedef word_t [15:0] win_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_BYTES = 6'b000010,
		ST_PAD   = 6'b000100,
		ST_COMP  = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam logic MODE_SHA1   = 1'b0;
	localparam logic MODE_SHA256 = 1'b1;

	localparam logic [6:0] LAST_RND_SHA1   = 7'd79;
	localparam logic [6:0] LAST_RND_SHA256 = 7'd63;
	localparam logic [2:0] LAST_OUT_SHA1   = 3'd4;
	localparam logic [2:0] LAST_OUT_SHA256 = 3'd7;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam word_t K1_0 = 32'h5a827999;
	localparam word_t K1_1 = 32'h6ed9eba1;
	localparam word_t K1_2 = 32'h8f1bbcdc;
	localparam word_t K1_3 = 32'hca62c1d6;

	localparam word_t K256 [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t rotl(word_t x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic chain_t init_chain(logic mode);
		chain_t c;
		if (mode == MODE_SHA256) begin
			c[0] = 32'h6a09e667; c[1] = 32'hbb67ae85;
			c[2] = 32'h3c6ef372; c[3] = 32'ha54ff53a;
			c[4] = 32'h510e527f; c[5] = 32'h9b05688c;
			c[6] = 32'h1f83d9ab; c[7] = 32'h5be0cd19;
		end else begin
			c[0] = 32'h67452301; c[1] = 32'hEFCDAB89;
			c[2] = 32'h98BADCFE; c[3] = 32'h10325476;
			c[4] = 32'hC3D2E1F0; c[5] = '0;
			c[6] = '0;           c[7] = '0;
		end
		return c;
	endfunction

endpackage

>>> hdl/shs_round.sv
module shs_round (
	input  logic            mode,
	input  logic [6:0]      rnd,
	input  shs_pkg::chain_t st_in,
	input  shs_pkg::win_t   win,
	output shs_pkg::chain_t st_out,
	output shs_pkg::word_t  w_new
);
	import shs_pkg::*;

	word_t f1, k1, t1, t2, s0, s1, x, y, ch, maj, t;

	always_comb begin
		st_out = st_in;
		if (mode == MODE_SHA256) begin
			s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
			s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
			w_new = s1 + win[9] + s0 + win[0];
			x = st_in[4];
			y = st_in[0];
			ch = (x & st_in[5]) ^ (~x & st_in[6]);
			maj = (y & st_in[1]) ^ (y & st_in[2]) ^ (st_in[1] & st_in[2]);
			t1 = st_in[7] + (rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25)) + ch
				+ K256[rnd[5:0]] + win[0];
			t2 = (rotr(y, 2) ^ rotr(y, 13) ^ rotr(y, 22)) + maj;
			f1 = '0; k1 = '0; t = '0;
			st_out[7] = st_in[6];
			st_out[6] = st_in[5];
			st_out[5] = st_in[4];
			st_out[4] = st_in[3] + t1;
			st_out[3] = st_in[2];
			st_out[2] = st_in[1];
			st_out[1] = st_in[0];
			st_out[0] = t1 + t2;
		end else begin
			s0 = '0; s1 = '0; x = '0; y = '0; ch = '0; maj = '0; t1 = '0; t2 = '0;
			w_new = rotl(win[13] ^ win[8] ^ win[2] ^ win[0], 1);
			if (rnd < 7'd20) begin
				f1 = (st_in[1] & st_in[2]) ^ (~st_in[1] & st_in[3]);
				k1 = K1_0;
			end else if (rnd < 7'd40) begin
				f1 = st_in[1] ^ st_in[2] ^ st_in[3];
				k1 = K1_1;
			end else if (rnd < 7'd60) begin
				f1 = (st_in[1] & st_in[2]) ^ (st_in[1] & st_in[3])
					^ (st_in[2] & st_in[3]);
				k1 = K1_2;
			end else begin
				f1 = st_in[1] ^ st_in[2] ^ st_in[3];
				k1 = K1_3;
			end
			t = rotl(st_in[0], 5) + f1 + st_in[4] + k1 + win[0];
			st_out[4] = st_in[3];
			st_out[3] = st_in[2];
			st_out[2] = rotl(st_in[1], 30);
			st_out[1] = st_in[0];
			st_out[0] = t;
		end
	end

endmodule

>>> hdl/sha1_sha256_hash_engine.sv
// SHA-1 / SHA-256 streaming hash engine.
// Input stream s_*: one message word per transfer, bytes big-endian. tlast marks
// the final word of a message; the byte count (0..4, larger counts act as 4)
// says how many leading bytes are valid. Short words may appear mid-message.
// Config channel cfg_*: one bit, 0 = SHA-1, 1 = SHA-256. A write abandons any
// message in progress and restarts with the new mode. cfg_ready is high only
// while idle; an offered config write takes precedence over input.
// Output stream m_*: 5 (SHA-1) or 8 (SHA-256) digest words after the last input
// word, first word first, tlast on the final word.
// Flow: an accepted input word writes its valid bytes into the block buffer one
// per cycle, held while a full block is compressed, and is then closed. Each
// full 64-byte block runs 80 (SHA-1) or 64 (SHA-256) rounds through the single
// shared round unit, then folds into the chaining words. Padding bytes go in
// the same way and add one or two blocks. s_tready is high only when idle and no
// config write is offered. The digest words are held until taken; a stalled
// receiver simply holds the engine in the output phase.
// Reset selects SHA-256 with its initial hash values and an empty message.
module sha1_sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero[39:35]
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word[31:0]
	output logic        m_tlast,   // digest_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // hash_mode
);
	import shs_pkg::*;

	state_t     state_q, ret_q;
	logic       mode_q;
	chain_t     chain_q, work_q, work_next;
	win_t       w_q;
	word_t      w_new;
	logic [5:0] fill_q;
	logic [63:0] bits_q;
	logic [31:0] word_q;
	logic [2:0] left_q;
	logic       last_q, first_q, len_q, pad_done_q;
	logic [2:0] len_idx_q, out_idx_q;
	logic [6:0] rnd_q;

	logic       wr_en;
	logic [7:0] wr_byte;
	logic [6:0] last_rnd;
	logic [2:0] last_out;
	logic [2:0] in_cnt;
	logic       out_xfer;

	shs_round u_round (
		.mode  (mode_q),
		.rnd   (rnd_q),
		.st_in (work_q),
		.win   (w_q),
		.st_out(work_next),
		.w_new (w_new)
	);

	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = chain_q[out_idx_q];
	assign last_rnd  = mode_q ? LAST_RND_SHA256 : LAST_RND_SHA1;
	assign last_out  = mode_q ? LAST_OUT_SHA256 : LAST_OUT_SHA1;
	assign m_tlast   = (out_idx_q == last_out);
	assign out_xfer  = m_tvalid && m_tready;
	assign in_cnt    = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

	always_comb begin
		wr_en = 1'b0;
		wr_byte = word_q[31:24];
		unique case (state_q)
			ST_BYTES: wr_en = (left_q != 3'd0);
			ST_PAD: begin
				wr_en = 1'b1;
				if (len_q)
					wr_byte = bits_q[{~len_idx_q, 3'b000} +: 8];
				else if (first_q)
					wr_byte = PAD_BYTE;
				else
					wr_byte = 8'h00;
			end
			ST_IDLE, ST_COMP, ST_FOLD, ST_OUT: wr_en = 1'b0;
			default: wr_en = 1'b0;
		endcase
	end

	// block buffer doubles as the message schedule window
	always_ff @(posedge clk) begin
		if (wr_en)
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
		else if (state_q == ST_COMP)
			w_q <= {w_new, w_q[15:1]};
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			word_q <= s_tdata[31:0];
		else if (state_q == ST_BYTES && wr_en)
			word_q <= {word_q[23:0], 8'h00};
		if (state_q == ST_COMP)
			work_q <= work_next;
		else
			work_q <= chain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_q      <= ST_BYTES;
			mode_q     <= MODE_SHA256;
			chain_q    <= init_chain(MODE_SHA256);
			fill_q     <= '0;
			bits_q     <= '0;
			left_q     <= '0;
			last_q     <= 1'b0;
			first_q    <= 1'b0;
			len_q      <= 1'b0;
			pad_done_q <= 1'b0;
			len_idx_q  <= '0;
			out_idx_q  <= '0;
			rnd_q      <= '0;
		end else begin
			if (wr_en) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63) begin
					ret_q   <= state_q;
					state_q <= ST_COMP;
					rnd_q   <= '0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						mode_q  <= cfg_data;
						chain_q <= init_chain(cfg_data);
						fill_q  <= '0;
						bits_q  <= '0;
					end else if (s_tvalid) begin
						left_q  <= in_cnt;
						last_q  <= s_tlast;
						state_q <= ST_BYTES;
					end
				end
				ST_BYTES: begin
					if (left_q != 3'd0) begin
						left_q <= left_q - 3'd1;
						bits_q <= bits_q + 64'd8;
					end else if (last_q) begin
						state_q    <= ST_PAD;
						first_q    <= 1'b1;
						len_q      <= 1'b0;
						len_idx_q  <= '0;
						pad_done_q <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (len_q) begin
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == 3'd7)
							pad_done_q <= 1'b1;
					end else if (fill_q == 6'd55) begin
						len_q <= 1'b1;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == last_rnd)
						state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++)
						chain_q[i] <= chain_q[i] + work_q[i];
					if (pad_done_q) begin
						state_q   <= ST_OUT;
						out_idx_q <= '0;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (m_tlast) begin
							chain_q    <= init_chain(mode_q);
							fill_q     <= '0;
							bits_q     <= '0;
							pad_done_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest pending");

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (rnd_q <= last_rnd))
		else $error("round counter past last round");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_tlast) |=> (fill_q == 6'd0 && bits_q == 64'd0 && state_q == ST_IDLE))
		else $error("engine not re-initialized after digest");

	a_comp_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && fill_q == 6'd63) |=> (state_q == ST_COMP && rnd_q == 7'd0))
		else $error("full block not compressed");
`endif

endmodule
